// File: rtl/core/mses_pkg.sv
// mses_pkg: shared types, constants and the ln(log2|z|) table for the escape shader core
// no dependencies; used by mandelbrot_escape_shader_core

package mses_pkg;

    // fixed-point format and picture geometry
    localparam int FRAC_BITS   = 28;
    localparam int WIDTH_LOG2  = 10;
    localparam int WIDTH       = 1 << WIDTH_LOG2;
    localparam int HEIGHT      = 1024;

    // field and datapath widths
    localparam int IDX_W       = 20;
    localparam int COL_W       = WIDTH_LOG2;
    localparam int ROW_W       = IDX_W - COL_W;
    localparam int ITER_W      = 12;
    localparam int SHADE_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int ORIGIN_W    = 32;
    localparam int STEP_W      = 31;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int CPROD_W     = STEP_W + COL_W;
    localparam int Z_W         = 45;
    localparam int SQ_W        = FRAC_BITS + 3;
    localparam int SSQ_W       = PROD_W - FRAC_BITS;
    localparam int KIDX_W      = 8;
    localparam int LNLOG_W     = 17;
    localparam int NUM_W       = ITER_W + 1 + 16 + 1;
    localparam int DEN_W       = ITER_W + 16 + 1;
    localparam int REM_W       = DEN_W - 1;
    localparam int DIV_CNT_W   = 3;

    // constants of the escape test and shading
    localparam logic [Z_W-1:0]    TWO_Q   = Z_W'(2) << FRAC_BITS;
    localparam logic [SQ_W:0]     FOUR_Q  = (SQ_W + 1)'(4) << FRAC_BITS;
    localparam logic [MUL_W-1:0]  SHADE_MAX = MUL_W'(255);
    localparam logic [KIDX_W-1:0] KIDX_MAX  = '1;
    localparam logic [31:0]       LN2_Q16 = 32'd45426;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd4;

    // configuration reset values
    localparam logic [ITER_W-1:0]   MAX_ITER_RST = 12'd256;
    localparam logic [ORIGIN_W-1:0] X_ORIGIN_RST = 32'hE000_0000;
    localparam logic [ORIGIN_W-1:0] Y_ORIGIN_RST = 32'hE800_0000;
    localparam logic [STEP_W-1:0]   X_STEP_RST   = 31'd786432;
    localparam logic [STEP_W-1:0]   Y_STEP_RST   = 31'd786432;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_X,
        ST_C_Y,
        ST_C_DONE,
        ST_IT_CHK,
        ST_IT_MX,
        ST_IT_MY,
        ST_IT_MXY,
        ST_IT_UPD,
        ST_E_CHK,
        ST_E_SX,
        ST_E_SY,
        ST_SH_TBL,
        ST_SH_MUL,
        ST_SH_DINIT,
        ST_SH_DIV,
        ST_FIN
    } state_t;

    typedef logic [LNLOG_W-1:0] lnlog_tab_t [0:255];

    // log2 of a Q30 value in [1, 2^33), result in Q16
    function automatic logic [31:0] log2_q16(input logic [63:0] v_in);
        logic [63:0] v;
        logic [31:0] r;
        v = v_in;
        r = '0;
        for (int s = 0; s < 40; s++)
        begin
            if (v >= (64'd2 << 30))
            begin
                v = v >> 1;
                r = r + 32'h0001_0000;
            end
        end
        for (int b = 15; b >= 0; b--)
        begin
            v = (v * v) >> 30;
            if (v >= (64'd2 << 30))
            begin
                v = v >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // entry k holds ln(log2(sqrt(k + 0.5))) in Q16, zero below four
    function automatic lnlog_tab_t build_lnlog();
        lnlog_tab_t t;
        logic [31:0] l;
        logic [31:0] h;
        logic [63:0] p;
        for (int k = 0; k < 256; k++)
        begin
            if (k < 4)
            begin
                t[k] = '0;
            end
            else
            begin
                l = log2_q16(64'(2 * k + 1) << 29);
                h = log2_q16(64'(l) << 13);
                p = (64'(h) * 64'(LN2_Q16)) >> 16;
                t[k] = p[LNLOG_W-1:0];
            end
        end
        return t;
    endfunction

    localparam lnlog_tab_t LNLOG_TABLE = build_lnlog();

endpackage

// File: rtl/core/mandelbrot_escape_shader_core.sv
// mandelbrot_escape_shader_core: escape-time shader with smooth shading, one shared multiplier
// depends on mses_pkg (constants, state type, ln(log2|z|) table)
//
//  channel  | signals                              | dir | beat
//  ---------+--------------------------------------+-----+----------------------------------
//  input    | in_valid, in_ready, pixel_index      | in  | one pixel number
//  output   | out_valid, out_ready, shade,         | out | grey level and iteration count
//           | iterations_used                      |     |
//  config   | cfg_we, cfg_index, cfg_data          | in  | one register write, no read-back
//
//  sequencing: each pixel is worked out on the single 32x32 multiplier: forming c, the
//    iterations of z, then the shading tail (escape radius, table, scale by 255, 8-step
//    restoring divide by the limit)
//  in_ready is high only while the sequencer is idle; a finished beat waits in the output
//    register, so the next pixel is taken while it is still pending
//  reset: configuration returns to its defaults, sequencer idle, output empty

module mandelbrot_escape_shader_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mses_pkg::IDX_W-1:0]        pixel_index,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mses_pkg::SHADE_W-1:0]      shade,
    output logic [mses_pkg::ITER_W-1:0]       iterations_used,

    input  logic                              cfg_we,
    input  logic [mses_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mses_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int F   = mses_pkg::FRAC_BITS;
    localparam int ZW  = mses_pkg::Z_W;
    localparam int SQW = mses_pkg::SQ_W;

    // configuration registers
    logic [mses_pkg::ITER_W-1:0]    max_iter_reg;
    logic [mses_pkg::ORIGIN_W-1:0]  x_origin_reg;
    logic [mses_pkg::ORIGIN_W-1:0]  y_origin_reg;
    logic [mses_pkg::STEP_W-1:0]    x_step_reg;
    logic [mses_pkg::STEP_W-1:0]    y_step_reg;

    // sequencer
    mses_pkg::state_t state_reg;
    mses_pkg::state_t state_next;

    // datapath registers
    logic [mses_pkg::IDX_W-1:0]      idx_reg;
    logic [mses_pkg::PROD_W-1:0]     prod_reg;
    logic signed [ZW-1:0]            cx_reg;
    logic signed [ZW-1:0]            cy_reg;
    logic signed [ZW-1:0]            zx_reg;
    logic signed [ZW-1:0]            zy_reg;
    logic [ZW-1:0]                   ax_reg;
    logic [ZW-1:0]                   ay_reg;
    logic [SQW-1:0]                  x2_reg;
    logic [SQW-1:0]                  y2_reg;
    logic [mses_pkg::ITER_W-1:0]     iter_reg;
    logic [mses_pkg::SSQ_W-1:0]      sx_reg;
    logic [mses_pkg::KIDX_W-1:0]     k_reg;
    logic signed [mses_pkg::NUM_W-1:0] num_reg;
    logic [mses_pkg::REM_W-1:0]      rem_reg;
    logic [7:0]                      nlo_reg;
    logic [mses_pkg::SHADE_W-1:0]    quo_reg;
    logic [mses_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    // output register
    logic                            out_valid_reg;
    logic [mses_pkg::SHADE_W-1:0]    shade_reg;
    logic [mses_pkg::ITER_W-1:0]     iter_out_reg;

    // combinational signals
    logic [mses_pkg::MUL_W-1:0]      mul_a;
    logic [mses_pkg::MUL_W-1:0]      mul_b;
    logic [ZW-1:0]                   ax_c;
    logic [ZW-1:0]                   ay_c;
    logic                            big_c;
    logic                            at_limit;
    logic [SQW-1:0]                  sq_c;
    logic [SQW:0]                    r2_c;
    logic                            r2_esc;
    logic                            neg_xy;
    logic signed [ZW-1:0]            zx_new;
    logic signed [ZW-1:0]            zy_new;
    logic signed [ZW-1:0]            xy2_c;
    logic                            far_c;
    logic [mses_pkg::SSQ_W:0]        s_c;
    logic [mses_pkg::KIDX_W-1:0]     k_c;
    logic [mses_pkg::LNLOG_W-1:0]    entry_c;
    logic [mses_pkg::ITER_W:0]       iter_p1;
    logic signed [mses_pkg::NUM_W-1:0] num_c;
    logic [mses_pkg::DEN_W-1:0]      den_c;
    logic [mses_pkg::DEN_W-1:0]      trial_c;
    logic                            ge_c;
    logic [mses_pkg::DEN_W-1:0]      diff_c;
    logic                            fin_load;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mses_pkg::MAX_ITER_RST;
            x_origin_reg <= mses_pkg::X_ORIGIN_RST;
            y_origin_reg <= mses_pkg::Y_ORIGIN_RST;
            x_step_reg   <= mses_pkg::X_STEP_RST;
            y_step_reg   <= mses_pkg::Y_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mses_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[mses_pkg::ITER_W-1:0];
                mses_pkg::CFG_X_ORIGIN: x_origin_reg <= cfg_data[mses_pkg::ORIGIN_W-1:0];
                mses_pkg::CFG_Y_ORIGIN: y_origin_reg <= cfg_data[mses_pkg::ORIGIN_W-1:0];
                mses_pkg::CFG_X_STEP:   x_step_reg   <= cfg_data[mses_pkg::STEP_W-1:0];
                mses_pkg::CFG_Y_STEP:   y_step_reg   <= cfg_data[mses_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // magnitudes of z and the component escape test
    always_comb
    begin
        ax_c     = zx_reg[ZW-1] ? ZW'(-zx_reg) : ZW'(zx_reg);
        ay_c     = zy_reg[ZW-1] ? ZW'(-zy_reg) : ZW'(zy_reg);
        big_c    = (ax_c > mses_pkg::TWO_Q) || (ay_c > mses_pkg::TWO_Q);
        at_limit = (iter_reg >= max_iter_reg);
    end

    // squared radius test and next z
    always_comb
    begin
        sq_c   = prod_reg[F+SQW-1:F];
        r2_c   = {1'b0, x2_reg} + {1'b0, sq_c};
        r2_esc = (r2_c > mses_pkg::FOUR_Q);
        neg_xy = zx_reg[ZW-1] ^ zy_reg[ZW-1];
        xy2_c  = $signed({{(ZW-SQW-1){1'b0}}, sq_c, 1'b0});
        zx_new = $signed({{(ZW-SQW){1'b0}}, x2_reg}) - $signed({{(ZW-SQW){1'b0}}, y2_reg})
                 + cx_reg;
        zy_new = (neg_xy ? -xy2_c : xy2_c) + cy_reg;
    end

    // escape radius index for the table
    always_comb
    begin
        far_c = (ax_reg[ZW-1:mses_pkg::MUL_W] != '0) || (ay_reg[ZW-1:mses_pkg::MUL_W] != '0);
        s_c   = {1'b0, sx_reg} + {1'b0, prod_reg[mses_pkg::PROD_W-1:F]};
        k_c   = (s_c[mses_pkg::SSQ_W:F] > (mses_pkg::SSQ_W - F + 1)'(mses_pkg::KIDX_MAX))
                ? mses_pkg::KIDX_MAX : s_c[F+mses_pkg::KIDX_W-1:F];
    end

    // shading numerator and divider step
    always_comb
    begin
        entry_c = mses_pkg::LNLOG_TABLE[k_reg];
        iter_p1 = {1'b0, iter_reg} + (mses_pkg::ITER_W + 1)'(1);
        num_c   = $signed({1'b0, iter_p1, 16'b0})
                  - $signed({{(mses_pkg::NUM_W - mses_pkg::LNLOG_W){1'b0}}, entry_c});
        den_c   = {1'b0, max_iter_reg, 16'b0};
        trial_c = {rem_reg, nlo_reg[7]};
        ge_c    = (trial_c >= den_c);
        diff_c  = trial_c - den_c;
        fin_load = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mses_pkg::ST_IDLE:     if (in_valid) state_next = mses_pkg::ST_C_X;
            mses_pkg::ST_C_X:      state_next = mses_pkg::ST_C_Y;
            mses_pkg::ST_C_Y:      state_next = mses_pkg::ST_C_DONE;
            mses_pkg::ST_C_DONE:   state_next = mses_pkg::ST_IT_CHK;
            mses_pkg::ST_IT_CHK:
            begin
                if (at_limit)
                    state_next = mses_pkg::ST_FIN;
                else if (big_c)
                    state_next = mses_pkg::ST_E_CHK;
                else
                    state_next = mses_pkg::ST_IT_MX;
            end
            mses_pkg::ST_IT_MX:    state_next = mses_pkg::ST_IT_MY;
            mses_pkg::ST_IT_MY:    state_next = mses_pkg::ST_IT_MXY;
            mses_pkg::ST_IT_MXY:   state_next = r2_esc ? mses_pkg::ST_E_CHK : mses_pkg::ST_IT_UPD;
            mses_pkg::ST_IT_UPD:   state_next = mses_pkg::ST_IT_CHK;
            mses_pkg::ST_E_CHK:    state_next = far_c ? mses_pkg::ST_SH_TBL : mses_pkg::ST_E_SX;
            mses_pkg::ST_E_SX:     state_next = mses_pkg::ST_E_SY;
            mses_pkg::ST_E_SY:     state_next = mses_pkg::ST_SH_TBL;
            mses_pkg::ST_SH_TBL:   state_next = mses_pkg::ST_SH_MUL;
            mses_pkg::ST_SH_MUL:
                state_next = num_reg[mses_pkg::NUM_W-1] ? mses_pkg::ST_FIN
                                                        : mses_pkg::ST_SH_DINIT;
            mses_pkg::ST_SH_DINIT: state_next = mses_pkg::ST_SH_DIV;
            mses_pkg::ST_SH_DIV:
                if (div_cnt_reg == '1) state_next = mses_pkg::ST_FIN;
            mses_pkg::ST_FIN:      if (fin_load) state_next = mses_pkg::ST_IDLE;
            default:               state_next = mses_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operands
    always_comb
    begin
        in_ready = (state_reg == mses_pkg::ST_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            mses_pkg::ST_C_X:
            begin
                mul_a = mses_pkg::MUL_W'(x_step_reg);
                mul_b = mses_pkg::MUL_W'(idx_reg[mses_pkg::COL_W-1:0]);
            end
            mses_pkg::ST_C_Y:
            begin
                mul_a = mses_pkg::MUL_W'(y_step_reg);
                mul_b = mses_pkg::MUL_W'(idx_reg[mses_pkg::IDX_W-1:mses_pkg::COL_W]);
            end
            mses_pkg::ST_IT_MX, mses_pkg::ST_E_CHK:
            begin
                mul_a = ax_reg[mses_pkg::MUL_W-1:0];
                mul_b = ax_reg[mses_pkg::MUL_W-1:0];
            end
            mses_pkg::ST_IT_MY, mses_pkg::ST_E_SX:
            begin
                mul_a = ay_reg[mses_pkg::MUL_W-1:0];
                mul_b = ay_reg[mses_pkg::MUL_W-1:0];
            end
            mses_pkg::ST_IT_MXY:
            begin
                mul_a = ax_reg[mses_pkg::MUL_W-1:0];
                mul_b = ay_reg[mses_pkg::MUL_W-1:0];
            end
            mses_pkg::ST_SH_MUL:
            begin
                mul_a = mses_pkg::MUL_W'(num_reg[mses_pkg::NUM_W-2:0]);
                mul_b = mses_pkg::SHADE_MAX;
            end
            default: ;
        endcase
    end

    // state and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mses_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mses_pkg::ST_FIN && fin_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // shared multiplier, product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mses_pkg::ST_IDLE:
                if (in_valid) idx_reg <= pixel_index;
            mses_pkg::ST_C_Y:
                cx_reg <= $signed({{(ZW-mses_pkg::ORIGIN_W){x_origin_reg[mses_pkg::ORIGIN_W-1]}},
                                   x_origin_reg})
                          + $signed({{(ZW-mses_pkg::CPROD_W){1'b0}},
                                     prod_reg[mses_pkg::CPROD_W-1:0]});
            mses_pkg::ST_C_DONE:
            begin
                cy_reg   <= $signed({{(ZW-mses_pkg::ORIGIN_W){y_origin_reg[mses_pkg::ORIGIN_W-1]}},
                                     y_origin_reg})
                            + $signed({{(ZW-mses_pkg::CPROD_W){1'b0}},
                                       prod_reg[mses_pkg::CPROD_W-1:0]});
                zx_reg   <= '0;
                zy_reg   <= '0;
                iter_reg <= '0;
            end
            mses_pkg::ST_IT_CHK:
            begin
                ax_reg <= ax_c;
                ay_reg <= ay_c;
                if (at_limit) quo_reg <= '0;
            end
            mses_pkg::ST_IT_MY:
                x2_reg <= sq_c;
            mses_pkg::ST_IT_MXY:
                y2_reg <= sq_c;
            mses_pkg::ST_IT_UPD:
            begin
                zx_reg   <= zx_new;
                zy_reg   <= zy_new;
                iter_reg <= iter_reg + mses_pkg::ITER_W'(1);
            end
            mses_pkg::ST_E_CHK:
                if (far_c) k_reg <= mses_pkg::KIDX_MAX;
            mses_pkg::ST_E_SX:
                sx_reg <= prod_reg[mses_pkg::PROD_W-1:F];
            mses_pkg::ST_E_SY:
                k_reg <= k_c;
            mses_pkg::ST_SH_TBL:
                num_reg <= num_c;
            mses_pkg::ST_SH_MUL:
                if (num_reg[mses_pkg::NUM_W-1]) quo_reg <= '0;
            mses_pkg::ST_SH_DINIT:
            begin
                rem_reg     <= prod_reg[mses_pkg::REM_W+7:8];
                nlo_reg     <= prod_reg[7:0];
                div_cnt_reg <= '0;
            end
            mses_pkg::ST_SH_DIV:
            begin
                rem_reg     <= ge_c ? diff_c[mses_pkg::REM_W-1:0] : trial_c[mses_pkg::REM_W-1:0];
                nlo_reg     <= {nlo_reg[6:0], 1'b0};
                quo_reg     <= {quo_reg[mses_pkg::SHADE_W-2:0], ge_c};
                div_cnt_reg <= div_cnt_reg + mses_pkg::DIV_CNT_W'(1);
            end
            mses_pkg::ST_FIN:
                if (fin_load)
                begin
                    shade_reg    <= quo_reg;
                    iter_out_reg <= iter_reg;
                end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign shade           = shade_reg;
    assign iterations_used = iter_out_reg;

endmodule
